/* src/gaussian_blur_3x3_assert.svh */
// assertion macros for the gaussian blur block
`ifndef GAUSSIAN_BLUR_3X3_ASSERT_SVH
`define GAUSSIAN_BLUR_3X3_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define GB3_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gaussian_blur_3x3: check failed");

// next-cycle implication, disabled while in reset
`define GB3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gaussian_blur_3x3: check failed");

`endif

/* src/gb3_pkg.sv */
// shared types and constants for the 3x3 gaussian blur
package gb3_pkg;

    localparam int PIX_W          = 8;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 1;
    localparam int ROW_W          = 16;

    localparam int RESET_FRAME_WIDTH  = 1024;
    localparam int RESET_FRAME_HEIGHT = 1024;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pixel_t;

    // 3x3 neighborhood: left, center and right columns, top to bottom
    typedef struct packed {
        pixel_t l_top;
        pixel_t l_mid;
        pixel_t l_bot;
        pixel_t c_top;
        pixel_t c_mid;
        pixel_t c_bot;
        pixel_t r_top;
        pixel_t r_mid;
        pixel_t r_bot;
    } gb3_win_t;

    // queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic empty;
    } gb3_q_status_t;

endpackage

/* src/gb3_front.sv */
// front part: position counters, line stores, window and result classification
module gb3_front #(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = $clog2(MAX_WIDTH)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [gb3_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [gb3_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [gb3_pkg::PIX_W-1:0]            pixel_in,
    input  gb3_pkg::gb3_q_status_t               q_status,
    output logic                                 push,
    output gb3_pkg::gb3_win_t                    win,
    output logic [gb3_pkg::ROW_W-1:0]            row,
    output logic [CW-1:0]                        col,
    output logic                                 last
);

    localparam int EW = CW + 1;
    localparam int RST_W_INT = (gb3_pkg::RESET_FRAME_WIDTH > MAX_WIDTH) ?
                               MAX_WIDTH : gb3_pkg::RESET_FRAME_WIDTH;
    localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);
    localparam logic [EW-1:0] RST_W_E = EW'(RST_W_INT);

    // effective frame size
    logic [EW-1:0]                   eff_w_reg;
    logic [gb3_pkg::ROW_W-1:0]       eff_h_reg;
    logic [EW-1:0]                   cfg_w_next;
    logic [gb3_pkg::ROW_W-1:0]       cfg_h_next;

    // position of the next input item
    logic [gb3_pkg::ROW_W-1:0]       row_reg;
    logic [gb3_pkg::ROW_W-1:0]       row_next;
    logic [CW-1:0]                   col_reg;
    logic [CW-1:0]                   col_next;
    logic                            col_wrap;
    logic                            row_wrap;
    logic                            emit_now;
    logic                            last_now;

    // item waiting for its line store data
    logic                            s1_valid_reg;
    logic                            s1_emit_reg;
    logic                            s1_last_reg;
    logic [gb3_pkg::PIX_W-1:0]       s1_pix_reg;
    logic [gb3_pkg::ROW_W-1:0]       s1_row_reg;
    logic [CW-1:0]                   s1_col_reg;
    logic [gb3_pkg::PIX_W-1:0]       top_rd_reg;
    logic [gb3_pkg::PIX_W-1:0]       mid_rd_reg;
    logic [gb3_pkg::PIX_W-1:0]       win_reg [6];

    logic [gb3_pkg::PIX_W-1:0]       upper_mem  [MAX_WIDTH];
    logic [gb3_pkg::PIX_W-1:0]       middle_mem [MAX_WIDTH];

    logic                            in_acc;
    logic                            s1_adv;

    // handshake: hold the input only when a result cannot enter the queue
    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || !q_status.full);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_acc   = in_valid && !in_stall;

    // clamp of written frame size
    always_comb
    begin
        if (cfg_data[gb3_pkg::FRAME_WIDTH_W-1:0] == '0)
            cfg_w_next = EW'(1);
        else if (32'(cfg_data[gb3_pkg::FRAME_WIDTH_W-1:0]) > 32'(MAX_WIDTH))
            cfg_w_next = MAX_W_E;
        else
            cfg_w_next = EW'(cfg_data[gb3_pkg::FRAME_WIDTH_W-1:0]);
        if (cfg_data[gb3_pkg::FRAME_HEIGHT_W-1:0] == '0)
            cfg_h_next = gb3_pkg::ROW_W'(1);
        else
            cfg_h_next = cfg_data[gb3_pkg::FRAME_HEIGHT_W-1:0];
    end

    // raster position step and classification
    always_comb
    begin
        col_wrap = ({1'b0, col_reg} + EW'(1)) >= eff_w_reg;
        row_wrap = ({1'b0, row_reg} + 17'd1) >= {1'b0, eff_h_reg};
        col_next = col_wrap ? '0 : col_reg + CW'(1);
        if (!col_wrap)
            row_next = row_reg;
        else if (row_wrap)
            row_next = '0;
        else
            row_next = row_reg + gb3_pkg::ROW_W'(1);
        emit_now = (row_reg >= gb3_pkg::ROW_W'(2)) && (col_reg >= CW'(2));
        last_now = (({1'b0, row_reg} + 17'd1) == {1'b0, eff_h_reg})
                && (({1'b0, col_reg} + EW'(1)) == eff_w_reg);
    end

    // configuration and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_w_reg <= RST_W_E;
            eff_h_reg <= gb3_pkg::ROW_W'(gb3_pkg::RESET_FRAME_HEIGHT);
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gb3_pkg::REG_FRAME_WIDTH:  eff_w_reg <= cfg_w_next;
                gb3_pkg::REG_FRAME_HEIGHT: eff_h_reg <= cfg_h_next;
                default:                   eff_w_reg <= eff_w_reg;
            endcase
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (in_acc)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // stage control and window columns
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            if (in_acc)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top_rd_reg;
                win_reg[4] <= mid_rd_reg;
                win_reg[5] <= s1_pix_reg;
            end
        end
    end

    // stage payload and line store reads
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_pix_reg  <= pixel_in;
            s1_row_reg  <= row_reg;
            s1_col_reg  <= col_reg;
            s1_emit_reg <= emit_now;
            s1_last_reg <= last_now;
            top_rd_reg  <= upper_mem[col_reg];
            mid_rd_reg  <= middle_mem[col_reg];
        end
    end

    // line store writes: rows move up by one
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            upper_mem[s1_col_reg]  <= mid_rd_reg;
            middle_mem[s1_col_reg] <= s1_pix_reg;
        end
    end

    // item handed to the queue
    assign push      = s1_adv && s1_emit_reg;
    assign win.l_top = win_reg[0];
    assign win.l_mid = win_reg[1];
    assign win.l_bot = win_reg[2];
    assign win.c_top = win_reg[3];
    assign win.c_mid = win_reg[4];
    assign win.c_bot = win_reg[5];
    assign win.r_top = top_rd_reg;
    assign win.r_mid = mid_rd_reg;
    assign win.r_bot = s1_pix_reg;
    assign row       = s1_row_reg - gb3_pkg::ROW_W'(1);
    assign col       = s1_col_reg - CW'(1);
    assign last      = s1_last_reg;

endmodule

/* src/gb3_queue.sv */
// short queue between the front and back parts
module gb3_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [WIDTH-1:0]       wdata,
    input  logic                   pop,
    output logic [WIDTH-1:0]       rdata,
    output gb3_pkg::gb3_q_status_t status
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;

    assign status.full  = (count_reg == (AW+1)'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign rdata        = slot_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (AW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (AW+1)'(1);
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            count_reg <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

endmodule

/* src/gb3_back.sv */
// back part: weighted 3x3 sum, rounding and output register
module gb3_back #(
    parameter int CW = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gb3_pkg::gb3_q_status_t        q_status,
    input  gb3_pkg::gb3_win_t             win,
    input  logic [gb3_pkg::ROW_W-1:0]     row,
    input  logic [CW-1:0]                 col,
    input  logic                          last,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [gb3_pkg::PIX_W-1:0]     pixel_out,
    output logic [gb3_pkg::ROW_W-1:0]     out_row,
    output logic [CW-1:0]                 out_col,
    output logic                          frame_last
);

    localparam int SW = gb3_pkg::PIX_W + 4;

    logic                          out_valid_reg;
    logic [gb3_pkg::PIX_W-1:0]     pixel_reg;
    logic [gb3_pkg::ROW_W-1:0]     row_reg;
    logic [CW-1:0]                 col_reg;
    logic                          last_reg;
    logic [SW-1:0]                 sum;
    logic [SW-1:0]                 rounded;

    // take the next item when the output register is free or draining
    assign pop = !q_status.empty && (!out_valid_reg || !out_stall);

    // kernel 1 2 1 / 2 4 2 / 1 2 1, then add half and drop four bits
    always_comb
    begin
        sum = SW'(win.l_top) + SW'({win.l_mid, 1'b0}) + SW'(win.l_bot)
            + SW'({win.c_top, 1'b0}) + SW'({win.c_mid, 2'b00}) + SW'({win.c_bot, 1'b0})
            + SW'(win.r_top) + SW'({win.r_mid, 1'b0}) + SW'(win.r_bot);
        rounded = sum + SW'(8);
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pixel_reg <= rounded[SW-1:4];
            row_reg   <= row;
            col_reg   <= col;
            last_reg  <= last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_reg;
    assign out_row    = row_reg;
    assign out_col    = col_reg;
    assign frame_last = last_reg;

endmodule

/* src/gaussian_blur_3x3.sv */
// path: a result passes the front stage register, the queue and the output register before it shows
// throughput: 1 item per clock unless stalled; each line store is read and written once per cycle
// border pixels are accepted at the same rate and give no result
// reset: counters, queue and valid flags clear at once; frame size returns to 1024 x 1024
// reset: line stores are not cleared and need no clearing pass
module gaussian_blur_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [gb3_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [gb3_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [gb3_pkg::PIX_W-1:0]              pixel_in,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [gb3_pkg::PIX_W-1:0]              pixel_out,
    output logic [gb3_pkg::ROW_W-1:0]              out_row,
    output logic [$clog2(MAX_WIDTH)-1:0]           out_col,
    output logic                                   frame_last
);

    `include "gaussian_blur_3x3_assert.svh"

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WINW = $bits(gb3_pkg::gb3_win_t);
    localparam int QW   = WINW + gb3_pkg::ROW_W + CW + 1;

    gb3_pkg::gb3_q_status_t        q_status;
    gb3_pkg::gb3_win_t             f_win;
    gb3_pkg::gb3_win_t             b_win;
    logic [gb3_pkg::ROW_W-1:0]     f_row;
    logic [CW-1:0]                 f_col;
    logic                          f_last;
    logic                          q_push;
    logic                          q_pop;
    logic [QW-1:0]                 q_wdata;
    logic [QW-1:0]                 q_rdata;

    // front: counters, line stores, window
    gb3_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel_in  (pixel_in),
        .q_status  (q_status),
        .push      (q_push),
        .win       (f_win),
        .row       (f_row),
        .col       (f_col),
        .last      (f_last)
    );

    // queue entry layout: last, col, row, window
    assign q_wdata = {f_last, f_col, f_row, f_win};

    gb3_queue #(
        .WIDTH (QW),
        .DEPTH (4)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    assign b_win = q_rdata[WINW-1:0];

    // back: arithmetic and output register
    gb3_back #(
        .CW (CW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .win        (b_win),
        .row        (q_rdata[WINW +: gb3_pkg::ROW_W]),
        .col        (q_rdata[WINW + gb3_pkg::ROW_W +: CW]),
        .last       (q_rdata[QW-1]),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_out  (pixel_out),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_last (frame_last)
    );

    // checks on front, queue and back coupling
    `GB3_ASSERT_NOW(a_no_push_when_full, clk, rst_n, q_push, !q_status.full)
    `GB3_ASSERT_NOW(a_stall_only_on_full, clk, rst_n, in_stall, q_status.full)
    `GB3_ASSERT_NEXT(a_pop_shows_result, clk, rst_n, q_pop, out_valid)

endmodule
